// ===== rtl/scaled_text_character_generator_top_assert.svh =====
// Assertion macros shared by the text generator modules.
`ifndef SCALED_TEXT_CHARACTER_GENERATOR_TOP_ASSERT_SVH
`define SCALED_TEXT_CHARACTER_GENERATOR_TOP_ASSERT_SVH

// Same-cycle implication, sampled on clk, off while rst is high.
`define STCG_ASSERT_IMP(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, sampled on clk, off while rst is high.
`define STCG_ASSERT_NXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== rtl/stcg_pkg.sv =====
// Shared types and constants for the scaled text character generator.
`timescale 1ns / 1ps
package stcg_pkg;

  localparam int FONT_GLYPHS_DEF = 256;
  localparam int MAX_SCALE_DEF   = 8;

  localparam int MODE_W      = 2;
  localparam int CHAR_W      = 8;
  localparam int COORD_W     = 16;
  localparam int FONT_ADDR_W = 11;
  localparam int FONT_DATA_W = 8;
  localparam int MASK_W      = 48;
  localparam int SCALE_W     = 4;
  localparam int SCREEN_W    = 10;
  localparam int CFG_IDX_W   = 3;
  localparam int CFG_DATA_W  = 16;
  localparam int GLYPH_COLS  = 5;
  localparam int CELL_COLS   = 6;
  localparam int GLYPH_ROWS  = 8;
  localparam int S_TDATA_W   = 64;
  localparam int M_TDATA_W   = 160;

  localparam logic [CHAR_W-1:0] CODE_LF         = 8'd10;
  localparam logic [CHAR_W-1:0] CODE_CR         = 8'd13;
  localparam logic [CHAR_W-1:0] CODE_CP437_GAP  = 8'd176;

  typedef enum logic [MODE_W-1:0] {
    MODE_CHAR   = 2'd0,
    MODE_CURSOR = 2'd1,
    MODE_FONT   = 2'd2,
    MODE_NONE   = 2'd3
  } mode_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_TEXT_SCALE     = 3'd0,
    REG_FG_COLOR       = 3'd1,
    REG_BG_COLOR       = 3'd2,
    REG_BG_TRANSPARENT = 3'd3,
    REG_LINE_WRAP      = 3'd4,
    REG_CHARSET_CP437  = 3'd5,
    REG_SCREEN_WIDTH   = 3'd6,
    REG_SCREEN_HEIGHT  = 3'd7
  } cfg_reg_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_DECODE,
    S_FETCH,
    S_STATUS,
    S_ROWS
  } state_t;

  typedef struct packed {
    logic load;          // capture the accepted request
    logic apply_simple;  // cursor load, font write, newline, carriage return
    logic place;         // line wrap and glyph lookup setup
    logic fetch;         // step through the glyph columns
    logic emit_status;   // load a status result
    logic emit_row;      // load the next pixel row
  } cmd_t;

  typedef struct packed {
    logic is_draw;
    logic fetch_done;
    logic visible;
    logic row_last;
    logic out_free;
  } stat_t;

endpackage

// ===== rtl/stcg_ctrl.sv =====
// Sequencer for the text generator: accept, decode, font fetch, row emission.
`timescale 1ns / 1ps
`include "scaled_text_character_generator_top_assert.svh"
module stcg_ctrl
  import stcg_pkg::*;
(
  input  logic  clk,
  input  logic  rst,
  input  logic  s_tvalid,
  output logic  s_tready,
  input  stat_t stat,
  output cmd_t  cmd
);

  state_t state, state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    cmd        = '0;
    s_tready   = 1'b0;
    unique case (state)
      S_IDLE: begin
        s_tready = 1'b1;
        if (s_tvalid) begin
          cmd.load   = 1'b1;
          state_next = S_DECODE;
        end
      end
      S_DECODE: begin
        if (stat.is_draw) begin
          cmd.place  = 1'b1;
          state_next = S_FETCH;
        end else begin
          cmd.apply_simple = 1'b1;
          state_next       = S_STATUS;
        end
      end
      S_FETCH: begin
        cmd.fetch = 1'b1;
        if (stat.fetch_done) begin
          state_next = stat.visible ? S_ROWS : S_STATUS;
        end
      end
      S_STATUS: begin
        if (stat.out_free) begin
          cmd.emit_status = 1'b1;
          state_next      = S_IDLE;
        end
      end
      S_ROWS: begin
        if (stat.out_free) begin
          cmd.emit_row = 1'b1;
          if (stat.row_last) begin
            state_next = S_IDLE;
          end
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  `STCG_ASSERT_IMP(a_emit_only_when_free, (cmd.emit_row || cmd.emit_status), stat.out_free, "result loaded over a pending one")
  `STCG_ASSERT_IMP(a_one_command, 1'b1, ($onehot0({cmd.load, cmd.apply_simple, cmd.place, cmd.fetch, cmd.emit_status, cmd.emit_row})), "more than one datapath command")
  `STCG_ASSERT_NXT(a_fetch_exit, (state == S_FETCH && stat.fetch_done), (state == S_ROWS || state == S_STATUS), "font fetch did not hand over")
  `STCG_ASSERT_NXT(a_last_row_idle, (cmd.emit_row && stat.row_last), (state == S_IDLE), "rows continued past last")

endmodule

// ===== rtl/stcg_datapath.sv =====
// Cursor, font store, glyph column buffer and pixel row output register.
`timescale 1ns / 1ps
`include "scaled_text_character_generator_top_assert.svh"
module stcg_datapath
  import stcg_pkg::*;
#(
  parameter int FONT_GLYPHS = FONT_GLYPHS_DEF,
  parameter int MAX_SCALE   = MAX_SCALE_DEF
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data,
  input  logic [S_TDATA_W-1:0]  s_tdata,
  input  logic [MODE_W-1:0]     s_tuser,
  input  cmd_t                  cmd,
  output stat_t                 stat,
  output logic                  m_tvalid,
  input  logic                  m_tready,
  output logic [M_TDATA_W-1:0]  m_tdata,
  output logic                  m_tuser,
  output logic                  m_tlast
);

  localparam int FONT_DEPTH = FONT_GLYPHS * GLYPH_COLS;
  localparam int FA_W       = $clog2(FONT_DEPTH);

  // configuration; colors are not kept here
  logic [SCALE_W-1:0]  text_scale;
  logic                bg_transparent;
  logic                line_wrap;
  logic                charset_cp437;
  logic [SCREEN_W-1:0] screen_width;
  logic [SCREEN_W-1:0] screen_height;

  always_ff @(posedge clk) begin
    if (rst) begin
      text_scale     <= SCALE_W'(1);
      bg_transparent <= 1'b1;
      line_wrap      <= 1'b1;
      charset_cp437  <= 1'b0;
      screen_width   <= SCREEN_W'(240);
      screen_height  <= SCREEN_W'(320);
    end else if (cfg_we) begin
      unique case (cfg_reg_t'(cfg_index))
        REG_TEXT_SCALE:     text_scale     <= cfg_data[SCALE_W-1:0];
        REG_FG_COLOR:       ;
        REG_BG_COLOR:       ;
        REG_BG_TRANSPARENT: bg_transparent <= cfg_data[0];
        REG_LINE_WRAP:      line_wrap      <= cfg_data[0];
        REG_CHARSET_CP437:  charset_cp437  <= cfg_data[0];
        REG_SCREEN_WIDTH:   screen_width   <= cfg_data[SCREEN_W-1:0];
        REG_SCREEN_HEIGHT:  screen_height  <= cfg_data[SCREEN_W-1:0];
        default: ;
      endcase
    end
  end

  // clamp scale into 1..MAX_SCALE
  logic [SCALE_W-1:0] s_eff;
  logic [5:0]         cell_w;
  logic [6:0]         cell_h;

  always_comb begin
    if (text_scale == '0) begin
      s_eff = SCALE_W'(1);
    end else if (text_scale > SCALE_W'(MAX_SCALE)) begin
      s_eff = SCALE_W'(MAX_SCALE);
    end else begin
      s_eff = text_scale;
    end
    cell_w = 6'(CELL_COLS * s_eff);
    cell_h = {s_eff[3:0], 3'b000};
  end

  // captured request
  mode_t                  item_mode;
  logic [CHAR_W-1:0]      item_code;
  logic [COORD_W-1:0]     item_nx;
  logic [COORD_W-1:0]     item_ny;
  logic [FONT_ADDR_W-1:0] item_faddr;
  logic [FONT_DATA_W-1:0] item_fdata;

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      item_mode  <= mode_t'(s_tuser);
      item_code  <= s_tdata[7:0];
      item_nx    <= s_tdata[23:8];
      item_ny    <= s_tdata[39:24];
      item_faddr <= s_tdata[50:40];
      item_fdata <= s_tdata[58:51];
    end
  end

  // cursor and cell geometry
  logic [COORD_W-1:0] cursor_col;
  logic [COORD_W-1:0] cursor_row;
  logic [COORD_W-1:0] x0;
  logic [COORD_W-1:0] y0;
  logic               visible;
  logic signed [COORD_W:0] col_ext, row_ext, sw_ext, sh_ext, cw_ext, ch_ext;
  logic wrap_hit, vis_now;

  always_comb begin
    col_ext  = $signed({cursor_col[COORD_W-1], cursor_col});
    row_ext  = $signed({cursor_row[COORD_W-1], cursor_row});
    sw_ext   = $signed({7'b0, screen_width});
    sh_ext   = $signed({7'b0, screen_height});
    cw_ext   = $signed({11'b0, cell_w});
    ch_ext   = $signed({10'b0, cell_h});
    wrap_hit = line_wrap && ((col_ext + cw_ext) >= sw_ext);
    vis_now  = !((col_ext >= sw_ext) || (row_ext >= sh_ext) ||
                 ((col_ext + cw_ext) <= 0) || ((row_ext + ch_ext) <= 0));
  end

  // glyph lookup
  logic [8:0]             glyph;
  logic [FONT_ADDR_W-1:0] glyph_base;
  logic                   glyph_oob;
  logic [2:0]             col_cnt;
  logic [FONT_DATA_W-1:0] cols [GLYPH_COLS];
  logic [FONT_DATA_W-1:0] font_q;

  always_comb begin
    glyph = {1'b0, item_code};
    if (!charset_cp437 && item_code >= CODE_CP437_GAP) begin
      glyph = glyph + 9'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.apply_simple) begin
      unique case (item_mode)
        MODE_CURSOR: begin
          cursor_col <= item_nx;
          cursor_row <= item_ny;
        end
        MODE_CHAR: begin
          cursor_col <= '0;
          if (item_code == CODE_LF) begin
            cursor_row <= cursor_row + COORD_W'(cell_h);
          end
        end
        MODE_FONT, MODE_NONE: ;
        default: ;
      endcase
    end else if (cmd.place) begin
      if (wrap_hit) begin
        cursor_col <= '0;
        cursor_row <= cursor_row + COORD_W'(cell_h);
      end
    end else if (cmd.fetch && col_cnt == '0) begin
      // cursor now holds the wrapped cell origin: keep it, then advance
      x0         <= cursor_col;
      y0         <= cursor_row;
      visible    <= vis_now;
      cursor_col <= cursor_col + COORD_W'(cell_w);
    end
    if (rst) begin
      cursor_col <= '0;
      cursor_row <= '0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.place) begin
      glyph_base <= FONT_ADDR_W'({glyph, 2'b00}) + FONT_ADDR_W'(glyph);
      glyph_oob  <= (glyph >= 9'(FONT_GLYPHS));
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      col_cnt <= '0;
    end else if (cmd.place) begin
      col_cnt <= '0;
    end else if (cmd.fetch && col_cnt != 3'(GLYPH_COLS)) begin
      col_cnt <= col_cnt + 3'd1;
    end
  end

  // font read data is registered: the column read at col_cnt is stored at col_cnt + 1
  always_ff @(posedge clk) begin
    if (cmd.fetch && col_cnt != '0) begin
      cols[col_cnt - 3'd1] <= glyph_oob ? '0 : font_q;
    end
  end

  // font store
  logic [FONT_DATA_W-1:0] font_mem [FONT_DEPTH];
  logic                   font_we, font_re;
  logic [FONT_ADDR_W-1:0] font_ra;

  assign font_we = cmd.apply_simple && (item_mode == MODE_FONT) &&
                   (item_faddr < FONT_ADDR_W'(FONT_DEPTH));
  assign font_re = cmd.fetch && (col_cnt < 3'(GLYPH_COLS)) && !glyph_oob;
  assign font_ra = glyph_base + FONT_ADDR_W'(col_cnt);

  always_ff @(posedge clk) begin
    if (font_we) begin
      font_mem[item_faddr[FA_W-1:0]] <= item_fdata;
    end
    if (font_re) begin
      font_q <= font_mem[font_ra[FA_W-1:0]];
    end
  end

  // row sequencing: sub counts repeats of one glyph row
  logic [2:0] sub;
  logic [2:0] gr;
  logic [5:0] ry;
  logic       row_last;

  assign row_last = (gr == 3'(GLYPH_ROWS - 1)) && (sub == 3'(s_eff - SCALE_W'(1)));

  always_ff @(posedge clk) begin
    if (cmd.place) begin
      sub <= '0;
      gr  <= '0;
      ry  <= '0;
    end else if (cmd.emit_row) begin
      ry <= ry + 6'd1;
      if (sub == 3'(s_eff - SCALE_W'(1))) begin
        sub <= '0;
        gr  <= gr + 3'd1;
      end else begin
        sub <= sub + 3'd1;
      end
    end
  end

  // pixel spans: column c covers pixels [c*s, (c+1)*s)
  logic [5:0]        bnd [CELL_COLS + 1];
  logic [MASK_W-1:0] fg_row, full_row, wr_row;

  always_comb begin
    for (int c = 0; c <= CELL_COLS; c++) begin
      bnd[c] = 6'(c * s_eff);
    end
    for (int k = 0; k < MASK_W; k++) begin
      full_row[k] = 6'(k) < bnd[CELL_COLS];
      fg_row[k]   = 1'b0;
      for (int c = 0; c < GLYPH_COLS; c++) begin
        if (6'(k) >= bnd[c] && 6'(k) < bnd[c + 1] && cols[c][gr]) begin
          fg_row[k] = 1'b1;
        end
      end
    end
    wr_row = bg_transparent ? fg_row : full_row;
  end

  // output register
  logic out_free;
  assign out_free = !m_tvalid || m_tready;

  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (cmd.emit_row || cmd.emit_status) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.emit_row) begin
      m_tuser <= 1'b1;
      m_tlast <= row_last;
      m_tdata <= {cursor_row, cursor_col, wr_row, fg_row, y0 + COORD_W'(ry), x0};
    end else if (cmd.emit_status) begin
      m_tuser <= 1'b0;
      m_tlast <= 1'b1;
      m_tdata <= {cursor_row, cursor_col, {(2 * MASK_W + 2 * COORD_W){1'b0}}};
    end
  end

  always_comb begin
    stat.is_draw    = (item_mode == MODE_CHAR) && (item_code != CODE_LF) &&
                      (item_code != CODE_CR);
    stat.fetch_done = (col_cnt == 3'(GLYPH_COLS));
    stat.visible    = visible;
    stat.row_last   = row_last;
    stat.out_free   = out_free;
  end

  `STCG_ASSERT_IMP(a_fg_within_write, (m_tvalid && m_tuser), ((m_tdata[79:32] & ~m_tdata[127:80]) == '0), "foreground pixel left unwritten")
  `STCG_ASSERT_IMP(a_status_is_last, (m_tvalid && !m_tuser), m_tlast, "status result not marked last")
  `STCG_ASSERT_NXT(a_font_read_in_range, font_re, (!glyph_oob), "font read past glyph set")

endmodule

// ===== rtl/scaled_text_character_generator_top.sv =====
// Top level of the scaled text character generator.
// Requests arrive on the s_ group: tuser carries the mode (0 draw character,
// 1 load cursor, 2 write one font byte), tdata the character code, cursor
// values and font address/byte. Results leave on the m_ group, one request
// giving either a single status result (tuser 0, tlast 1) or 8*scale pixel
// rows (tuser 1, tlast on the final row), each with the cursor after the
// request. Registers are written through cfg_we/cfg_index/cfg_data; the user is
// to write them only while idle, as the block has no check for it. A request
// is taken in S_IDLE and decoded in S_DECODE; a drawn character then reads
// its five columns from the font RAM (one read port, registered data) and
// emits one row per cycle while the receiver accepts. Cursor, font, newline
// and carriage-return requests go from decode to a status result; an
// off-screen character still reads its glyph, then gives a status result.
// A new request is taken as soon as the last result is loaded into the
// output register, even while that result still waits for m_tready.
// Reset clears the cursor, the registers to their defaults and the output
// valid; the font RAM is not cleared and must be loaded before use.
// When the receiver stalls, the output register holds and row emission waits.
`timescale 1ns / 1ps
module scaled_text_character_generator_top
  import stcg_pkg::*;
#(
  parameter int FONT_GLYPHS = FONT_GLYPHS_DEF,
  parameter int MAX_SCALE   = MAX_SCALE_DEF
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data,
  input  logic                  s_tvalid,
  output logic                  s_tready,
  // char_code[7:0], new_cursor_x[23:8], new_cursor_y[39:24],
  // font_address[50:40], font_data[58:51], zero fill above
  input  logic [S_TDATA_W-1:0]  s_tdata,
  // mode[1:0]
  input  logic [MODE_W-1:0]     s_tuser,
  output logic                  m_tvalid,
  input  logic                  m_tready,
  // row_x[15:0], row_y[31:16], foreground_mask[79:32], write_mask[127:80],
  // cursor_x_now[143:128], cursor_y_now[159:144]
  output logic [M_TDATA_W-1:0]  m_tdata,
  // row_valid
  output logic                  m_tuser,
  output logic                  m_tlast
);

  cmd_t  cmd;
  stat_t stat;

  stcg_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .stat     (stat),
    .cmd      (cmd)
  );

  stcg_datapath #(
    .FONT_GLYPHS (FONT_GLYPHS),
    .MAX_SCALE   (MAX_SCALE)
  ) u_datapath (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .s_tdata   (s_tdata),
    .s_tuser   (s_tuser),
    .cmd       (cmd),
    .stat      (stat),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_tdata   (m_tdata),
    .m_tuser   (m_tuser),
    .m_tlast   (m_tlast)
  );

endmodule
